FILE: rtl/core/rpv_pkg.sv
package rpv_pkg;

    localparam int HDR_BYTES     = 16;
    localparam int CNT_W         = 13;
    localparam int SIZE_W        = 13;
    localparam int SIZE_CMP_W    = 18;
    localparam int MAX_REC_DEF   = 4096;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // request operation codes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_FAIL  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_VALID     = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_BAD_CRC   = 3'd4;
    localparam logic [2:0] ST_READ_FAIL = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_SIZE    = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       slot;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        slot_ok;
        logic [31:0] record_seq;
        logic        any_valid;
        logic        active_slot;
        logic [31:0] active_seq;
        logic        commit_slot;
        logic [31:0] commit_seq;
    } result_t;

    // what the scanner hands to the selector for one request
    typedef struct packed {
        logic              clear;
        logic              fail;
        logic              done;
        logic              slot;
        logic [31:0]       magic;
        logic [15:0]       version;
        logic [15:0]       length;
        logic [31:0]       hdr_crc;
        logic [31:0]       pay_crc;
        logic [31:0]       seq;
        logic [SIZE_W-1:0] len_limit;
    } scan_evt_t;

    // reflected crc-32, one byte, eight unrolled steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/rpv_scan.sv
module rpv_scan
    import rpv_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_REC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  item_t             item,
    input  logic [SIZE_W-1:0] record_size,
    output scan_evt_t         evt
);

    logic [CNT_W-1:0] byte_count_reg,  byte_count_next;
    logic [31:0]      hdr_magic_reg,   hdr_magic_next;
    logic [15:0]      hdr_version_reg, hdr_version_next;
    logic [15:0]      hdr_length_reg,  hdr_length_next;
    logic [31:0]      hdr_crc_reg,     hdr_crc_next;
    logic [31:0]      hdr_seq_reg,     hdr_seq_next;
    logic [31:0]      crc_reg,         crc_next;

    logic [SIZE_W-1:0] size_eff;
    logic [CNT_W:0]    pos_plus;
    logic              last_byte;
    logic [CNT_W-1:0]  pay_pos;
    logic [7:0]        b;

    assign b = item.data_byte;

    // record size clamped to header .. maximum
    always_comb
    begin
        size_eff = record_size;
        if ({{(SIZE_CMP_W-SIZE_W){1'b0}}, record_size} < SIZE_CMP_W'(HDR_BYTES))
        begin
            size_eff = SIZE_W'(HDR_BYTES);
        end
        else if ({{(SIZE_CMP_W-SIZE_W){1'b0}}, record_size} > SIZE_CMP_W'(MAX_RECORD_BYTES))
        begin
            size_eff = SIZE_W'(MAX_RECORD_BYTES);
        end
    end

    assign pos_plus  = {1'b0, byte_count_reg} + (CNT_W+1)'(1);
    assign last_byte = pos_plus >= {1'b0, size_eff};
    assign pay_pos   = byte_count_reg - CNT_W'(HDR_BYTES);

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        hdr_magic_next   = hdr_magic_reg;
        hdr_version_next = hdr_version_reg;
        hdr_length_next  = hdr_length_reg;
        hdr_crc_next     = hdr_crc_reg;
        hdr_seq_next     = hdr_seq_reg;
        crc_next         = crc_reg;
        unique case (item.op)
            OP_BEGIN, OP_FAIL:
            begin
                byte_count_next = '0;
                crc_next        = CRC_ONES;
            end
            OP_BYTE:
            begin
                priority if (byte_count_reg < CNT_W'(4))
                begin
                    hdr_magic_next[byte_count_reg[1:0]*8 +: 8] = b;
                end
                else if (byte_count_reg < CNT_W'(6))
                begin
                    hdr_version_next[byte_count_reg[0]*8 +: 8] = b;
                end
                else if (byte_count_reg < CNT_W'(8))
                begin
                    hdr_length_next[byte_count_reg[0]*8 +: 8] = b;
                end
                else if (byte_count_reg < CNT_W'(12))
                begin
                    hdr_crc_next[byte_count_reg[1:0]*8 +: 8] = b;
                end
                else if (byte_count_reg < CNT_W'(HDR_BYTES))
                begin
                    hdr_seq_next[byte_count_reg[1:0]*8 +: 8] = b;
                end
                else if ({3'd0, pay_pos} < hdr_length_reg)
                begin
                    crc_next = crc_byte(crc_reg, b);
                end
                else
                begin
                    // padding past the declared payload
                end
                if (last_byte)
                begin
                    byte_count_next = '0;
                end
                else
                begin
                    byte_count_next = pos_plus[CNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        evt.clear     = item.op == OP_BEGIN;
        evt.fail      = item.op == OP_FAIL;
        evt.done      = (item.op == OP_BYTE) && last_byte;
        evt.slot      = item.slot;
        evt.magic     = hdr_magic_next;
        evt.version   = hdr_version_next;
        evt.length    = hdr_length_next;
        evt.hdr_crc   = hdr_crc_next;
        evt.pay_crc   = crc_next ^ CRC_ONES;
        evt.seq       = hdr_seq_next;
        evt.len_limit = size_eff - SIZE_W'(HDR_BYTES);
    end

    // crc restarts on the slot's last byte as well
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            hdr_magic_reg   <= '0;
            hdr_version_reg <= '0;
            hdr_length_reg  <= '0;
            hdr_crc_reg     <= '0;
            hdr_seq_reg     <= '0;
            crc_reg         <= CRC_ONES;
        end
        else if (step)
        begin
            byte_count_reg  <= byte_count_next;
            hdr_magic_reg   <= hdr_magic_next;
            hdr_version_reg <= hdr_version_next;
            hdr_length_reg  <= hdr_length_next;
            hdr_crc_reg     <= hdr_crc_next;
            hdr_seq_reg     <= hdr_seq_next;
            crc_reg         <= (evt.done ? CRC_ONES : crc_next);
        end
    end

endmodule

FILE: rtl/core/rpv_select.sv
module rpv_select
    import rpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  scan_evt_t   evt,
    input  logic [31:0] expected_magic,
    input  logic [15:0] expected_version,
    output logic        res_valid,
    output result_t     res
);

    logic        have_valid_reg,  have_valid_next;
    logic        chosen_slot_reg, chosen_slot_next;
    logic [31:0] chosen_seq_reg,  chosen_seq_next;

    logic [2:0]  status;
    logic [31:0] seq_diff;
    logic        newer;

    always_comb
    begin
        priority if (evt.magic != expected_magic)
        begin
            status = ST_BAD_MAGIC;
        end
        else if (evt.version != expected_version)
        begin
            status = ST_BAD_VER;
        end
        else if (evt.length > {3'd0, evt.len_limit})
        begin
            status = ST_BAD_LEN;
        end
        else if (evt.pay_crc != evt.hdr_crc)
        begin
            status = ST_BAD_CRC;
        end
        else
        begin
            status = ST_VALID;
        end
    end

    // newer by signed wrap difference
    assign seq_diff = evt.seq - chosen_seq_reg;
    assign newer    = (seq_diff != 32'd0) && !seq_diff[31];

    always_comb
    begin
        have_valid_next  = have_valid_reg;
        chosen_slot_next = chosen_slot_reg;
        chosen_seq_next  = chosen_seq_reg;
        if (evt.clear)
        begin
            have_valid_next  = 1'b0;
            chosen_slot_next = 1'b0;
            chosen_seq_next  = '0;
        end
        else if (evt.done && (status == ST_VALID) && (!have_valid_reg || newer))
        begin
            have_valid_next  = 1'b1;
            chosen_slot_next = evt.slot;
            chosen_seq_next  = evt.seq;
        end
    end

    always_comb
    begin
        res_valid       = evt.done || evt.fail;
        res.status      = evt.fail ? ST_READ_FAIL : status;
        res.slot_ok     = !evt.fail && (status == ST_VALID);
        res.record_seq  = evt.fail ? 32'd0 : evt.seq;
        res.any_valid   = have_valid_next;
        res.active_slot = chosen_slot_next;
        res.active_seq  = chosen_seq_next;
        res.commit_slot = have_valid_next && !chosen_slot_next;
        res.commit_seq  = chosen_seq_next + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_valid_reg  <= 1'b0;
            chosen_slot_reg <= 1'b0;
            chosen_seq_reg  <= '0;
        end
        else if (step)
        begin
            have_valid_reg  <= have_valid_next;
            chosen_slot_reg <= chosen_slot_next;
            chosen_seq_reg  <= chosen_seq_next;
        end
    end

endmodule

FILE: rtl/core/ping_pong_record_validator_unit.sv
// dual-slot record validator: each slot image arrives one byte per request,
// a 16-byte little-endian header (magic, version, payload length, crc,
// sequence) followed by payload, record_size bytes per slot. a reflected
// crc-32 runs over the first payload-length payload bytes. on a slot's last
// byte, or on a read-failed request, one result comes out with the slot's
// status and the current selection plus the next commit target; begin-scan
// requests clear the selection and give no result. throughput is one request
// per clock while results are taken, set by the combinational crc byte update
// (eight unrolled shift/xor steps) between the request and result registers.
// each request passes through the request register and then the result
// register. configuration registers are to be written by the user through
// the cfg port only while idle, which the block itself does not enforce;
// they take effect immediately.
module ping_pong_record_validator_unit
    import rpv_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_REC_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [31:0]       exp_magic_reg;
    logic [15:0]       exp_version_reg;
    logic [SIZE_W-1:0] record_size_reg;

    // request register
    logic  req_valid_reg;
    item_t req_reg;

    // result register
    logic    res_valid_reg;
    result_t res_reg;

    logic      advance;
    scan_evt_t evt;
    logic      sel_valid;
    result_t   sel_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_magic_reg   <= '0;
            exp_version_reg <= 16'd1;
            record_size_reg <= SIZE_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAGIC:   exp_magic_reg   <= cfg_data;
                CFG_VERSION: exp_version_reg <= cfg_data[15:0];
                CFG_SIZE:    record_size_reg <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // the request in the register is processed once the result slot is free
    // or being drained this cycle
    assign advance    = req_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            req_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            req_reg <= item;
        end
    end

    rpv_scan #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (req_reg),
        .record_size (record_size_reg),
        .evt         (evt)
    );

    rpv_select u_select (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .evt              (evt),
        .expected_magic   (exp_magic_reg),
        .expected_version (exp_version_reg),
        .res_valid        (sel_valid),
        .res              (sel_res)
    );

    // result register, reloaded or emptied as the consumer takes results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= sel_valid;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sel_valid)
        begin
            res_reg <= sel_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // a held request is never dropped while the result side stalls
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !advance |=> req_valid_reg)
        else $error("request register lost a pending request");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.slot_ok == (result.status == ST_VALID)))
        else $error("slot_ok disagrees with status");

    a_fail_seq: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_READ_FAIL) |-> (result.record_seq == 32'd0))
        else $error("read failure carries a sequence");

    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.commit_seq == result.active_seq + 32'd1)
                      && (result.commit_slot == (result.any_valid && !result.active_slot)))
        else $error("commit target inconsistent with selection");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.any_valid |-> (result.active_seq == 32'd0)
                                           && !result.active_slot)
        else $error("empty selection not cleared");

endmodule
